// ===== hdl/servo_status_packet_deframer_assert.svh =====
// ----------------------------------------------------------------------------
// servo status packet deframer assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SERVO_STATUS_PACKET_DEFRAMER_ASSERT_SVH
`define SERVO_STATUS_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define SSPD_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("sspd assertion failed");

// next-cycle implication
`define SSPD_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("sspd assertion failed");

`endif

// ===== hdl/sspd_pkg.sv =====
// ----------------------------------------------------------------------------
// sspd_pkg
// shared types, constants and crc function of the status packet deframer
// ----------------------------------------------------------------------------
package sspd_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0]  BYTE_FF     = 8'hFF;
   localparam logic [7:0]  BYTE_FD     = 8'hFD;
   localparam logic [7:0]  INST_STATUS = 8'h55;
   localparam logic [15:0] CRC_POLY    = 16'h8005;
   localparam logic [15:0] LEN_MIN     = 16'd4;

   localparam logic KIND_PARAM   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       is_ff;
      logic       is_fd;
      logic       is_status;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // crc after the three header bytes
   localparam logic [15:0] CRC_HEADER =
      crc_add(crc_add(crc_add(16'h0000, BYTE_FF), BYTE_FF), BYTE_FD);

endpackage

// ===== hdl/servo_status_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// servo_status_packet_deframer
// status packet deframer: header hunt, field capture, parameter stream and
// crc-16 checked end summary
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_stall   req_rx_byte
//  rsp_      out        rsp_valid/rsp_stall   kind, data_byte, packet_id,
//                                             error_code, param_count, crc_ok
//
//  one byte per cycle sustained while the result is not stalled, set by the back
//  state machine taking one queue entry per cycle; a byte passes through the
//  queue into the result register. reset clears the queue, the packet state and
//  the result valid flag. a stalled result holds the back end; the queue keeps
//  taking requests until it holds QUEUE_DEPTH bytes.
// ----------------------------------------------------------------------------
module servo_status_packet_deframer #(
   parameter int QUEUE_DEPTH = sspd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_packet_id,
   output logic [7:0]  rsp_error_code,
   output logic [15:0] rsp_param_count,
   output logic        rsp_crc_ok
);
   import sspd_pkg::*;

   q_status_type q_status;
   entry_type    push_entry;
   entry_type    pop_entry;
   logic         push;
   logic         pop;

   sspd_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_rx_byte(req_rx_byte),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   sspd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .pop_entry (pop_entry),
      .q_status  (q_status)
   );

   sspd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .pop_entry      (pop_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_packet_id  (rsp_packet_id),
      .rsp_error_code (rsp_error_code),
      .rsp_param_count(rsp_param_count),
      .rsp_crc_ok     (rsp_crc_ok)
   );

endmodule

// ===== hdl/sspd_front.sv =====
// ----------------------------------------------------------------------------
// sspd_front
// accepts received bytes and tags header and instruction codes for the queue
// ----------------------------------------------------------------------------
module sspd_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   input  sspd_pkg::q_status_type q_status,
   output logic                  push,
   output sspd_pkg::entry_type   push_entry
);
   import sspd_pkg::*;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      push_entry.rx_byte   = req_rx_byte;
      push_entry.is_ff     = (req_rx_byte == BYTE_FF);
      push_entry.is_fd     = (req_rx_byte == BYTE_FD);
      push_entry.is_status = (req_rx_byte == INST_STATUS);
   end

endmodule

// ===== hdl/sspd_queue.sv =====
// ----------------------------------------------------------------------------
// sspd_queue
// short fifo of tagged bytes between front and back
// ----------------------------------------------------------------------------
module sspd_queue #(
   parameter int DEPTH = sspd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sspd_pkg::entry_type    push_entry,
   input  logic                   pop,
   output sspd_pkg::entry_type    pop_entry,
   output sspd_pkg::q_status_type q_status
);
   import sspd_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   entry_type       slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastIdx) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastIdx) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry          = slot_ff[rd_ptr_ff];
   assign q_status.not_empty = (count_ff != '0);
   assign q_status.full      = (count_ff == FullCnt);

endmodule

// ===== hdl/sspd_back.sv =====
// ----------------------------------------------------------------------------
// sspd_back
// packet state machine, crc and registered result output
// ----------------------------------------------------------------------------
module sspd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sspd_pkg::q_status_type q_status,
   input  sspd_pkg::entry_type    pop_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_kind,
   output logic [7:0]             rsp_data_byte,
   output logic [7:0]             rsp_packet_id,
   output logic [7:0]             rsp_error_code,
   output logic [15:0]            rsp_param_count,
   output logic                   rsp_crc_ok
);
   import sspd_pkg::*;

   localparam logic [3:0] PH_HUNT0 = 4'd0;
   localparam logic [3:0] PH_HUNT1 = 4'd1;
   localparam logic [3:0] PH_HUNT2 = 4'd2;
   localparam logic [3:0] PH_RSV   = 4'd3;
   localparam logic [3:0] PH_ID    = 4'd4;
   localparam logic [3:0] PH_LENL  = 4'd5;
   localparam logic [3:0] PH_LENH  = 4'd6;
   localparam logic [3:0] PH_INST  = 4'd7;
   localparam logic [3:0] PH_ERR   = 4'd8;
   localparam logic [3:0] PH_PARAM = 4'd9;
   localparam logic [3:0] PH_CRCL  = 4'd10;
   localparam logic [3:0] PH_CRCH  = 4'd11;
   localparam logic [3:0] PH_SKIP  = 4'd12;

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  err_ff, err_in;
   logic        low_match_ff, low_match_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff;
   logic [7:0]  rsp_data_ff;
   logic [7:0]  rsp_id_ff;
   logic [7:0]  rsp_err_ff;
   logic [15:0] rsp_count_ff;
   logic        rsp_ok_ff;

   logic        emit;
   logic        emit_kind;
   logic [7:0]  emit_data;
   logic        emit_ok;
   logic [7:0]  b;
   logic [15:0] crc_next;

   assign pop      = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);
   assign b        = pop_entry.rx_byte;
   assign crc_next = crc_add(crc_ff, b);

   always_comb begin
      phase_in     = phase_ff;
      crc_in       = crc_ff;
      length_in    = length_ff;
      left_in      = left_ff;
      id_in        = id_ff;
      err_in       = err_ff;
      low_match_in = low_match_ff;
      emit         = 1'b0;
      emit_kind    = KIND_PARAM;
      emit_data    = 8'h00;
      emit_ok      = 1'b0;
      case (phase_ff)
         PH_HUNT0: begin
            phase_in = pop_entry.is_ff ? PH_HUNT1 : PH_HUNT0;
         end
         PH_HUNT1: begin
            phase_in = pop_entry.is_ff ? PH_HUNT2 : PH_HUNT0;
         end
         PH_HUNT2: begin
            if (pop_entry.is_ff) begin
               phase_in = PH_HUNT2;
            end else if (pop_entry.is_fd) begin
               crc_in   = CRC_HEADER;
               phase_in = PH_RSV;
            end else begin
               phase_in = PH_HUNT0;
            end
         end
         PH_RSV: begin
            crc_in   = crc_next;
            phase_in = PH_ID;
         end
         PH_ID: begin
            crc_in   = crc_next;
            id_in    = b;
            phase_in = PH_LENL;
         end
         PH_LENL: begin
            crc_in    = crc_next;
            length_in = {8'h00, b};
            phase_in  = PH_LENH;
         end
         PH_LENH: begin
            crc_in    = crc_next;
            length_in = {b, length_ff[7:0]};
            phase_in  = ({b, length_ff[7:0]} < LEN_MIN) ? PH_HUNT0 : PH_INST;
         end
         PH_INST: begin
            crc_in = crc_next;
            if (pop_entry.is_status) begin
               phase_in = PH_ERR;
            end else begin
               left_in  = length_ff - 16'd1;
               phase_in = PH_SKIP;
            end
         end
         PH_ERR: begin
            crc_in   = crc_next;
            err_in   = b;
            left_in  = length_ff - LEN_MIN;
            phase_in = (length_ff == LEN_MIN) ? PH_CRCL : PH_PARAM;
         end
         PH_PARAM: begin
            crc_in    = crc_next;
            emit      = 1'b1;
            emit_kind = KIND_PARAM;
            emit_data = b;
            left_in   = left_ff - 16'd1;
            if (left_ff == 16'd1) begin
               phase_in = PH_CRCL;
            end
         end
         PH_CRCL: begin
            low_match_in = (b == crc_ff[7:0]);
            phase_in     = PH_CRCH;
         end
         PH_CRCH: begin
            emit      = 1'b1;
            emit_kind = KIND_SUMMARY;
            emit_ok   = low_match_ff && (b == crc_ff[15:8]);
            phase_in  = PH_HUNT0;
         end
         PH_SKIP: begin
            left_in = left_ff - 16'd1;
            if (left_ff == 16'd1) begin
               phase_in = PH_HUNT0;
            end
         end
         default: begin
            phase_in = PH_HUNT0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT0;
         crc_ff       <= '0;
         length_ff    <= '0;
         left_ff      <= '0;
         id_ff        <= '0;
         err_ff       <= '0;
         low_match_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff     <= phase_in;
            crc_ff       <= crc_in;
            length_ff    <= length_in;
            left_ff      <= left_in;
            id_ff        <= id_in;
            err_ff       <= err_in;
            low_match_ff <= low_match_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_kind_ff  <= emit_kind;
         rsp_data_ff  <= emit_data;
         rsp_id_ff    <= id_ff;
         rsp_err_ff   <= err_ff;
         rsp_count_ff <= length_ff - LEN_MIN;
         rsp_ok_ff    <= emit_ok;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_data_byte   = rsp_data_ff;
   assign rsp_packet_id   = rsp_id_ff;
   assign rsp_error_code  = rsp_err_ff;
   assign rsp_param_count = rsp_count_ff;
   assign rsp_crc_ok      = rsp_ok_ff;

endmodule

// ===== hdl/sspd_checker.sv =====
// ----------------------------------------------------------------------------
// sspd_checker
// port-level checks of the status packet deframer, bound to the top level
// ----------------------------------------------------------------------------
`include "servo_status_packet_deframer_assert.svh"

module sspd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic [7:0]  rsp_packet_id,
   input logic [7:0]  rsp_error_code,
   input logic [15:0] rsp_param_count,
   input logic        rsp_crc_ok
);

   `SSPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_data_byte) && $stable(rsp_packet_id) &&
      $stable(rsp_error_code) && $stable(rsp_param_count) && $stable(rsp_crc_ok))
   `SSPD_ASSERT_IMPLY(a_summary_data_zero, clock, reset, rsp_valid && rsp_kind,
      rsp_data_byte == 8'h00)
   `SSPD_ASSERT_IMPLY(a_param_no_crc, clock, reset, rsp_valid && !rsp_kind, !rsp_crc_ok)
   `SSPD_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid && !req_stall)

endmodule

bind servo_status_packet_deframer sspd_checker u_checker (.*);

// ===== test/servo_status_packet_deframer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_status_packet_deframer_tb
// feeds byte streams of status packets, other packets, short lengths and
// broken headers into the deframer, with random gaps and stalls on both
// channels, and compares every parameter byte and end summary against an
// independent deframing state machine with its own crc-16
// ----------------------------------------------------------------------------
module servo_status_packet_deframer_tb;
   import sspd_pkg::*;

   localparam int BYTE_TARGET    = 850;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 20;

   localparam int CRC_FAULT_NONE = 0;
   localparam int CRC_FAULT_LOW  = 1;
   localparam int CRC_FAULT_HIGH = 2;

   typedef enum logic [3:0] {
      HUNT_IDLE, HUNT_ONE_FF, HUNT_TWO_FF, TAKE_RSV, TAKE_ID, TAKE_LEN_LO,
      TAKE_LEN_HI, TAKE_INST, TAKE_ERR, TAKE_PARAM, TAKE_CRC_LO, TAKE_CRC_HI,
      SKIP_BODY
   } deframe_phase_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  packet_id;
      logic [7:0]  error_code;
      logic [15:0] param_count;
      logic        crc_ok;
   } deframe_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_packet_id;
   logic [7:0]  rsp_error_code;
   logic [15:0] rsp_param_count;
   logic        rsp_crc_ok;

   deframe_result_type expected_results[$];
   int                 mismatch_count;
   int                 bytes_sent;
   int                 idle_cycles;
   bit                 no_gap_stretch;

   // deframer state as predicted
   deframe_phase_type  dp_phase;
   logic [15:0]        dp_crc;
   logic [15:0]        dp_length;
   logic [15:0]        dp_left;
   logic [7:0]         dp_id;
   logic [7:0]         dp_error;
   logic               dp_crc_low_ok;

   servo_status_packet_deframer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_packet_id   (rsp_packet_id),
      .rsp_error_code  (rsp_error_code),
      .rsp_param_count (rsp_param_count),
      .rsp_crc_ok      (rsp_crc_ok)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // crc-16, poly 0x8005, msb first, one input bit at a time
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] random_payload();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) begin
         return BYTE_FF;
      end else if (r < 30) begin
         return BYTE_FD;
      end else if (r < 35) begin
         return INST_STATUS;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void push_result(input logic kind, input logic [7:0] data,
                                       input logic ok);
      deframe_result_type r;
      r.kind        = kind;
      r.data_byte   = data;
      r.packet_id   = dp_id;
      r.error_code  = dp_error;
      r.param_count = dp_length - LEN_MIN;
      r.crc_ok      = ok;
      expected_results.push_back(r);
   endfunction

   // advance the predicted deframer by one accepted byte
   function automatic void deframe_byte(input logic [7:0] b);
      case (dp_phase)
         HUNT_IDLE: begin
            dp_phase = (b == BYTE_FF) ? HUNT_ONE_FF : HUNT_IDLE;
         end
         HUNT_ONE_FF: begin
            dp_phase = (b == BYTE_FF) ? HUNT_TWO_FF : HUNT_IDLE;
         end
         HUNT_TWO_FF: begin
            if (b == BYTE_FF) begin
               dp_phase = HUNT_TWO_FF;
            end else if (b == BYTE_FD) begin
               dp_crc   = crc_step(crc_step(crc_step(16'h0000, BYTE_FF), BYTE_FF), BYTE_FD);
               dp_phase = TAKE_RSV;
            end else begin
               dp_phase = HUNT_IDLE;
            end
         end
         TAKE_RSV: begin
            dp_crc   = crc_step(dp_crc, b);
            dp_phase = TAKE_ID;
         end
         TAKE_ID: begin
            dp_crc   = crc_step(dp_crc, b);
            dp_id    = b;
            dp_phase = TAKE_LEN_LO;
         end
         TAKE_LEN_LO: begin
            dp_crc    = crc_step(dp_crc, b);
            dp_length = {8'h00, b};
            dp_phase  = TAKE_LEN_HI;
         end
         TAKE_LEN_HI: begin
            dp_crc    = crc_step(dp_crc, b);
            dp_length = {b, dp_length[7:0]};
            dp_phase  = (dp_length < LEN_MIN) ? HUNT_IDLE : TAKE_INST;
         end
         TAKE_INST: begin
            dp_crc = crc_step(dp_crc, b);
            if (b == INST_STATUS) begin
               dp_phase = TAKE_ERR;
            end else begin
               dp_left  = dp_length - 16'd1;
               dp_phase = SKIP_BODY;
            end
         end
         TAKE_ERR: begin
            dp_crc   = crc_step(dp_crc, b);
            dp_error = b;
            dp_left  = dp_length - LEN_MIN;
            dp_phase = (dp_left == 16'd0) ? TAKE_CRC_LO : TAKE_PARAM;
         end
         TAKE_PARAM: begin
            dp_crc = crc_step(dp_crc, b);
            push_result(KIND_PARAM, b, 1'b0);
            dp_left = dp_left - 16'd1;
            if (dp_left == 16'd0) begin
               dp_phase = TAKE_CRC_LO;
            end
         end
         TAKE_CRC_LO: begin
            dp_crc_low_ok = (b == dp_crc[7:0]);
            dp_phase      = TAKE_CRC_HI;
         end
         TAKE_CRC_HI: begin
            push_result(KIND_SUMMARY, 8'h00, dp_crc_low_ok && (b == dp_crc[15:8]));
            dp_phase = HUNT_IDLE;
         end
         SKIP_BODY: begin
            dp_left = dp_left - 16'd1;
            if (dp_left == 16'd0) begin
               dp_phase = HUNT_IDLE;
            end
         end
         default: begin
            dp_phase = HUNT_IDLE;
         end
      endcase
   endfunction

   task automatic apply_reset();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_rx_byte   = 8'h00;
      dp_phase      = HUNT_IDLE;
      dp_crc        = 16'h0000;
      dp_length     = 16'h0000;
      dp_left       = 16'h0000;
      dp_id         = 8'h00;
      dp_error      = 8'h00;
      dp_crc_low_ok = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   endtask

   task automatic idle_sender(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // one request, held until the deframer takes it
   task automatic send_byte(input logic [7:0] b);
      if (!no_gap_stretch && $urandom_range(0, 99) < 25) begin
         idle_sender(pick_gap());
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      deframe_byte(b);
      bytes_sent++;
   endtask

   task automatic send_packet(input logic [7:0] id, input logic [15:0] len,
                              input logic [7:0] inst, input logic [7:0] err,
                              input int extra_ff, input int crc_fault);
      logic [7:0]  pkt[$];
      logic [15:0] crc;
      pkt = {};
      repeat (extra_ff) pkt.push_back(BYTE_FF);
      pkt.push_back(BYTE_FF);
      pkt.push_back(BYTE_FF);
      pkt.push_back(BYTE_FD);
      pkt.push_back(8'($urandom_range(0, 255)));
      pkt.push_back(id);
      pkt.push_back(len[7:0]);
      pkt.push_back(len[15:8]);
      if (len >= LEN_MIN) begin
         pkt.push_back(inst);
         if (inst == INST_STATUS) begin
            pkt.push_back(err);
            repeat (int'(len) - 4) pkt.push_back(random_payload());
            crc = 16'h0000;
            for (int i = extra_ff; i < pkt.size(); i++) begin
               crc = crc_step(crc, pkt[i]);
            end
            if (crc_fault == CRC_FAULT_LOW) begin
               crc[7:0] = crc[7:0] ^ (8'h01 << $urandom_range(0, 7));
            end else if (crc_fault == CRC_FAULT_HIGH) begin
               crc[15:8] = crc[15:8] ^ (8'h01 << $urandom_range(0, 7));
            end
            pkt.push_back(crc[7:0]);
            pkt.push_back(crc[15:8]);
         end else begin
            repeat (int'(len) - 1) pkt.push_back(random_payload());
         end
      end
      foreach (pkt[i]) send_byte(pkt[i]);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_overlapping_header();
      send_packet(8'h00, 16'd4, INST_STATUS, 8'hFF, 1, CRC_FAULT_NONE);
   endtask

   task automatic test_short_length();
      send_packet(8'hFF, 16'd3, INST_STATUS, 8'h00, 0, CRC_FAULT_NONE);
   endtask

   task automatic test_broken_header();
      send_byte(BYTE_FF);
      send_byte(BYTE_FD);
      send_byte(8'h00);
   endtask

   task automatic test_long_packet();
      send_packet(8'hA5, 16'h0104, INST_STATUS, 8'h5A, 0, CRC_FAULT_NONE);
   endtask

   task automatic test_drain_pause();
      send_packet(8'h3C, 16'd6, INST_STATUS, 8'h81, 0, CRC_FAULT_NONE);
      wait_for_drain();
      send_packet(8'hC3, 16'd5, INST_STATUS, 8'h7E, 2, CRC_FAULT_LOW);
   endtask

   task automatic test_random_traffic();
      int          r;
      logic [7:0]  inst;
      logic [15:0] len;
      while (bytes_sent < BYTE_TARGET) begin
         no_gap_stretch = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 62) begin
            len = 16'($urandom_range(0, 9) == 0 ? $urandom_range(13, 40)
                                                : $urandom_range(4, 12));
            r = $urandom_range(0, 9);
            send_packet(8'($urandom_range(0, 255)), len, INST_STATUS,
                        8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0 ?
                        $urandom_range(1, 3) : 0,
                        r < 8 ? CRC_FAULT_NONE : (r == 8 ? CRC_FAULT_LOW : CRC_FAULT_HIGH));
         end else if (r < 74) begin
            inst = 8'($urandom_range(0, 255));
            if (inst == INST_STATUS) begin
               inst = ~inst;
            end
            send_packet(8'($urandom_range(0, 255)), 16'($urandom_range(4, 14)), inst,
                        8'h00, 0, CRC_FAULT_NONE);
         end else if (r < 84) begin
            send_packet(8'($urandom_range(0, 255)), 16'($urandom_range(0, 3)),
                        INST_STATUS, 8'h00, $urandom_range(0, 1), CRC_FAULT_NONE);
         end else begin
            // noise that never forms a full header
            repeat ($urandom_range(1, 6)) begin
               inst = $urandom_range(0, 2) == 0 ? BYTE_FF : 8'($urandom_range(0, 255));
               send_byte(inst == BYTE_FD ? 8'hFC : inst);
            end
         end
         if ($urandom_range(0, 99) < 3) begin
            wait_for_drain();
         end
      end
      no_gap_stretch = 1'b0;
   endtask

   // receiver: stretches with no stall and stretches with random stalls
   initial begin
      int stretch;
      int style;
      int hold_left;
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         stretch = $urandom_range(16, 160);
         style   = $urandom_range(0, 3);
         repeat (stretch) begin
            @(negedge clock);
            if (hold_left > 0) begin
               rsp_stall <= 1'b1;
               hold_left--;
            end else if (style != 0 && $urandom_range(0, 99) < 25) begin
               hold_left = pick_gap() - 1;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   task automatic log_mismatch(input string what, input deframe_result_type want,
                               input deframe_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected kind=%0d data=%02h id=%02h err=%02h count=%0d ok=%0d",
                  what, want.kind, want.data_byte, want.packet_id, want.error_code,
                  want.param_count, want.crc_ok);
         $display("   actual kind=%0d data=%02h id=%02h err=%02h count=%0d ok=%0d",
                  got.kind, got.data_byte, got.packet_id, got.error_code,
                  got.param_count, got.crc_ok);
      end
   endtask

   always @(posedge clock) begin
      deframe_result_type got;
      deframe_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_kind, rsp_data_byte, rsp_packet_id, rsp_error_code,
                rsp_param_count, rsp_crc_ok};
         if (expected_results.size() == 0) begin
            log_mismatch("unexpected result", '0, got);
         end else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                got.packet_id !== want.packet_id || got.error_code !== want.error_code ||
                got.param_count !== want.param_count || got.crc_ok !== want.crc_ok) begin
               log_mismatch("result mismatch", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("servo_status_packet_deframer regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      mismatch_count = 0;
      bytes_sent     = 0;
      idle_cycles    = 0;
      no_gap_stretch = 1'b0;
      apply_reset();
      test_overlapping_header();
      test_short_length();
      test_broken_header();
      test_long_packet();
      test_drain_pause();
      test_random_traffic();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("servo_status_packet_deframer regression: pass");
      end else begin
         $display("servo_status_packet_deframer regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sspd_pkg.sv
hdl/sspd_front.sv
hdl/sspd_queue.sv
hdl/sspd_back.sv
hdl/servo_status_packet_deframer.sv
hdl/sspd_checker.sv
test/servo_status_packet_deframer_tb.sv
